// ===== sv/hnc_pkg.sv =====
// Package with shared types, constants and functions of the Hangul NFC composer.
package hnc_pkg;

  localparam logic [20:0] JAMO_L_BASE = 21'h01100;
  localparam logic [20:0] JAMO_L_END  = 21'h01113;
  localparam logic [20:0] JAMO_V_BASE = 21'h01161;
  localparam logic [20:0] JAMO_V_END  = 21'h01176;
  localparam logic [20:0] JAMO_T_BASE = 21'h011A7;
  localparam logic [20:0] JAMO_T_END  = 21'h011C3;
  localparam logic [20:0] SYL_BASE    = 21'h0AC00;
  localparam logic [20:0] SYL_END     = 21'h0D7A4;
  localparam logic [14:0] SYL_N_CNT   = 15'd588;
  localparam logic [9:0]  JAMO_T_CNT  = 10'd28;

  localparam int unsigned BurstLen = 7;

  typedef enum logic [1:0] {
    HOLD_NONE = 2'd0,
    HOLD_L    = 2'd1,
    HOLD_LV   = 2'd2
  } hold_kind_e;

  // Shortest-form UTF-8 encoding of one code point; bytes[0] goes out first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } enc_t;

  // Output bytes caused by one input item; bytes[0] goes out first.
  typedef struct packed {
    logic [BurstLen-1:0][7:0] bytes;
    logic [2:0]               count;
  } burst_t;

  function automatic enc_t enc_code(input logic [20:0] c);
    enc_t e;
    e.bytes = '0;
    if (c < 21'h00080) begin
      e.bytes[0] = c[7:0];
      e.len      = 3'd1;
    end else if (c < 21'h00800) begin
      e.bytes[0] = {3'b110, c[10:6]};
      e.bytes[1] = {2'b10, c[5:0]};
      e.len      = 3'd2;
    end else if (c < 21'h10000) begin
      e.bytes[0] = {4'b1110, c[15:12]};
      e.bytes[1] = {2'b10, c[11:6]};
      e.bytes[2] = {2'b10, c[5:0]};
      e.len      = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, c[20:18]};
      e.bytes[1] = {2'b10, c[17:12]};
      e.bytes[2] = {2'b10, c[11:6]};
      e.bytes[3] = {2'b10, c[5:0]};
      e.len      = 3'd4;
    end
    return e;
  endfunction

  function automatic logic is_l(input logic [20:0] c);
    return (c >= JAMO_L_BASE) && (c < JAMO_L_END);
  endfunction

  function automatic logic is_v(input logic [20:0] c);
    return (c >= JAMO_V_BASE) && (c < JAMO_V_END);
  endfunction

  function automatic logic is_t(input logic [20:0] c);
    return (c > JAMO_T_BASE) && (c < JAMO_T_END);
  endfunction

  // A precomposed LV syllable has an offset from the syllable base that is a
  // multiple of 28: a multiple of 4 whose quarter is a multiple of 7. The
  // test by 7 sums octal digits, since 8 is one more than 7.
  function automatic logic is_lv(input logic [20:0] c);
    logic [20:0] off;
    logic [11:0] q;
    logic [4:0]  s1;
    logic [3:0]  s2;
    off = c - SYL_BASE;
    q   = off[13:2];
    s1  = 5'(q[2:0]) + 5'(q[5:3]) + 5'(q[8:6]) + 5'(q[11:9]);
    s2  = 4'(s1[2:0]) + 4'(s1[4:3]);
    return (c >= SYL_BASE) && (c < SYL_END) && (off[1:0] == 2'b00) &&
           ((s2 == 4'd0) || (s2 == 4'd7));
  endfunction

endpackage

// ===== sv/hnc_in_if.sv =====
// Input byte channel: valid/ready handshake with opcode and data byte.
interface hnc_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

// ===== sv/hnc_out_if.sv =====
// Output byte channel: valid/ready handshake with output byte and last flag.
interface hnc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== sv/hnc_decode.sv =====
// UTF-8 decoder with Hangul cluster state and burst building for one byte.
module hnc_decode import hnc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic       opcode_i,
  input  logic [7:0] data_byte_i,
  output burst_t     burst_o
);

  logic [20:0] pc_q, pc_d;
  logic [1:0]  bn_q, bn_d;
  hold_kind_e  hk_q, hk_d;
  logic [15:0] hc_q, hc_d;

  logic [20:0] cont_code;
  logic [20:0] code;
  logic [20:0] out_code;
  logic        take;
  logic        held;
  logic        rel;
  logic        emit_code;
  logic        emit_raw;
  logic [15:0] l_diff;
  logic [20:0] v_diff;
  logic [20:0] t_diff;
  logic [14:0] l_off;
  logic [9:0]  v_off;
  logic [15:0] syl;
  enc_t        enc_a;
  enc_t        enc_b;
  logic [3:0][7:0] sec_bytes;
  logic [2:0]  sec_len;

  assign cont_code = {pc_q[14:0], data_byte_i[5:0]};
  assign code      = (bn_q != 2'd0) ? cont_code : {13'd0, data_byte_i};
  assign held      = (hk_q == HOLD_L) || (hk_q == HOLD_LV);

  // LV composition from the held L jamo and the incoming vowel.
  assign l_diff = hc_q - JAMO_L_BASE[15:0];
  assign v_diff = code - JAMO_V_BASE;
  assign t_diff = code - JAMO_T_BASE;
  assign l_off  = 15'(l_diff[4:0]) * SYL_N_CNT;
  assign v_off  = 10'(v_diff[4:0]) * JAMO_T_CNT;
  assign syl    = SYL_BASE[15:0] + 16'(l_off) + 16'(v_off);

  always_comb begin
    pc_d      = pc_q;
    bn_d      = bn_q;
    hk_d      = hk_q;
    hc_d      = hc_q;
    take      = 1'b0;
    rel       = 1'b0;
    emit_code = 1'b0;
    emit_raw  = 1'b0;
    out_code  = code;

    if (opcode_i) begin
      rel  = held;
      hk_d = HOLD_NONE;
      hc_d = '0;
      pc_d = '0;
      bn_d = '0;
    end else if (bn_q != 2'd0) begin
      pc_d = cont_code;
      bn_d = bn_q - 2'd1;
      if (bn_q == 2'd1) begin
        pc_d = '0;
        take = 1'b1;
      end
    end else if (!data_byte_i[7]) begin
      take = 1'b1;
    end else if (data_byte_i[7:5] == 3'b110) begin
      pc_d = {16'd0, data_byte_i[4:0]};
      bn_d = 2'd1;
    end else if (data_byte_i[7:4] == 4'b1110) begin
      pc_d = {17'd0, data_byte_i[3:0]};
      bn_d = 2'd2;
    end else if (data_byte_i[7:3] == 5'b11110) begin
      pc_d = {18'd0, data_byte_i[2:0]};
      bn_d = 2'd3;
    end else begin
      // Lone continuation byte or F8..FF passes through raw.
      rel      = held;
      hk_d     = HOLD_NONE;
      hc_d     = '0;
      emit_raw = 1'b1;
    end

    if (take) begin
      priority if ((hk_q == HOLD_L) && is_v(code)) begin
        hc_d = syl;
        hk_d = HOLD_LV;
      end else if ((hk_q == HOLD_LV) && is_t(code)) begin
        out_code  = {5'd0, hc_q + 16'(t_diff[4:0])};
        emit_code = 1'b1;
        hk_d      = HOLD_NONE;
        hc_d      = '0;
      end else begin
        rel = held;
        priority if (is_l(code)) begin
          hk_d = HOLD_L;
          hc_d = code[15:0];
        end else if (is_lv(code)) begin
          hk_d = HOLD_LV;
          hc_d = code[15:0];
        end else begin
          hk_d      = HOLD_NONE;
          hc_d      = '0;
          emit_code = 1'b1;
        end
      end
    end
  end

  // The held cluster always encodes in three bytes; the second piece follows.
  assign enc_a = enc_code({5'd0, hc_q});
  assign enc_b = enc_code(out_code);

  always_comb begin
    sec_bytes = '0;
    sec_len   = 3'd0;
    if (emit_raw) begin
      sec_bytes[0] = data_byte_i;
      sec_len      = 3'd1;
    end else if (emit_code) begin
      sec_bytes = enc_b.bytes;
      sec_len   = enc_b.len;
    end

    burst_o.bytes = '0;
    if (rel) begin
      burst_o.bytes[0] = enc_a.bytes[0];
      burst_o.bytes[1] = enc_a.bytes[1];
      burst_o.bytes[2] = enc_a.bytes[2];
      burst_o.bytes[3] = sec_bytes[0];
      burst_o.bytes[4] = sec_bytes[1];
      burst_o.bytes[5] = sec_bytes[2];
      burst_o.bytes[6] = sec_bytes[3];
      burst_o.count    = 3'd3 + sec_len;
    end else begin
      burst_o.bytes[0] = sec_bytes[0];
      burst_o.bytes[1] = sec_bytes[1];
      burst_o.bytes[2] = sec_bytes[2];
      burst_o.bytes[3] = sec_bytes[3];
      burst_o.count    = sec_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      bn_q <= '0;
      hk_q <= HOLD_NONE;
      hc_q <= '0;
    end else if (accept_i) begin
      pc_q <= pc_d;
      bn_q <= bn_d;
      hk_q <= hk_d;
      hc_q <= hc_d;
    end
  end

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && opcode_i) |=> ((bn_q == 2'd0) && (hk_q == HOLD_NONE) && (pc_q == '0)))
    else $error("flush did not return the decoder state to reset");

  a_held_l_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hk_q == HOLD_L) |-> ((hc_q >= JAMO_L_BASE[15:0]) && (hc_q < JAMO_L_END[15:0])))
    else $error("held leading jamo out of range");

  a_held_lv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hk_q == HOLD_LV) |-> ((hc_q >= SYL_BASE[15:0]) && (hc_q < SYL_END[15:0])))
    else $error("held LV syllable out of range");

endmodule

// ===== sv/hnc_burst_out.sv =====
// Output burst register that shifts one byte out per transfer.
module hnc_burst_out import hnc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  burst_t     burst_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       free_o
);

  logic [BurstLen-1:0][7:0] bytes_q, bytes_d;
  logic [2:0]               rem_q, rem_d;
  logic                     xfer;
  logic                     last;

  assign out_valid_o = (rem_q != 3'd0);
  assign last        = (rem_q == 3'd1);
  assign xfer        = out_valid_o && out_ready_i;
  assign out_byte_o  = bytes_q[0];
  assign run_last_o  = last;
  assign free_o      = !out_valid_o || (xfer && last);

  always_comb begin
    bytes_d = bytes_q;
    rem_d   = rem_q;
    if (load_i) begin
      bytes_d = burst_i.bytes;
      rem_d   = burst_i.count;
    end else if (xfer) begin
      bytes_d = {8'd0, bytes_q[BurstLen-1:1]};
      rem_d   = rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ((rem_q == 3'd0) || (out_ready_i && (rem_q == 3'd1))))
    else $error("burst loaded over undelivered bytes");

  a_shift_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && !last && !load_i) |=> (out_valid_o && (out_byte_o == $past(bytes_q[1]))))
    else $error("burst bytes not delivered in order");

  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && last && !load_i) |=> !out_valid_o)
    else $error("output still valid after final transfer");

endmodule

// ===== sv/hangul_nfc_compose_utf8_stream_top.sv =====
// Top level of the Hangul NFC composing UTF-8 stream normalizer.
// The first output byte of an accepted input byte is valid in the cycle after its transfer.
// One input byte per cycle while the output is ready and each causes at most one output byte;
// an item causing N output bytes (up to 7) stalls input until the single output register drains.
// Reset (rst_ni, asynchronous, active low) clears the decoder and hold state and empties the
// output register; no clearing pass is needed.
module hangul_nfc_compose_utf8_stream_top import hnc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  hnc_in_if.sink    in_i,
  hnc_out_if.source out_o
);

  // A transfer on the input side is taken whenever the output register is empty or is
  // handing over its final byte in the same cycle, so single-byte results stream at full rate.
  logic   in_xfer;
  logic   load;
  logic   free;
  burst_t burst;

  assign in_i.ready = free;
  assign in_xfer    = in_i.valid && free;

  // The decoder updates the UTF-8 and Hangul cluster state on each transfer and builds the
  // bytes that this input item causes, in delivery order.
  hnc_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_xfer),
    .opcode_i    (in_i.opcode),
    .data_byte_i (in_i.data_byte),
    .burst_o     (burst)
  );

  // Items that cause no output, such as lead bytes or a held jamo, leave the output
  // register untouched.
  assign load = in_xfer && (burst.count != 3'd0);

  hnc_burst_out u_burst_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .burst_i     (burst),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .run_last_o  (out_o.run_last),
    .free_o      (free)
  );

endmodule
